/* rtl/bgas_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgas_pkg
// Shared types, constants and helpers of the banded global alignment scorer.
// ----------------------------------------------------------------------------
package bgas_pkg;

	localparam int BAND_LANES_DEF  = 16;
	localparam int MAX_SEQ_LEN_DEF = 1024;
	localparam int SCORE_W         = 16;
	localparam int SYM_W           = 8;
	localparam int POS_W           = 10;
	localparam int LEN_W           = 11;
	localparam int CFG_IDX_W       = 2;

	localparam logic [SYM_W-1:0] PAD_A = 8'h31;
	localparam logic [SYM_W-1:0] PAD_B = 8'h32;

	// request codes
	typedef enum logic [1:0] {
		CMD_LOAD_A = 2'd0,
		CMD_LOAD_B = 2'd1,
		CMD_RUN    = 2'd2,
		CMD_NOP    = 2'd3
	} bgas_cmd_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MATCH    = 2'd0,
		REG_MISMATCH = 2'd1,
		REG_GAP      = 2'd2,
		REG_MINUS_INF = 2'd3
	} bgas_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PRIME,
		S_FILL,
		S_RUN,
		S_DONE
	} bgas_state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load_a;
		logic load_b;
		logic run_init;
		logic prime;
		logic fill;
		logic step;
	} bgas_ctrl_t;

	// datapath to controller status
	typedef struct packed {
		logic fill_last;
		logic diag_zero;
		logic diag_one;
	} bgas_stat_t;

	// signed maximum of two scores
	function automatic logic [SCORE_W-1:0] smax(input logic [SCORE_W-1:0] a,
		input logic [SCORE_W-1:0] b);
		return ($signed(b) > $signed(a)) ? b : a;
	endfunction

endpackage

/* rtl/bgas_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgas_ram
// Generic memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bgas_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write, then registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/bgas_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgas_ctrl
// Sequencer: takes requests, runs prime, window fill and diagonal sweep.
// ----------------------------------------------------------------------------
module bgas_ctrl
	import bgas_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] cmd,
	input  bgas_stat_t stat,
	output bgas_ctrl_t ctrl,
	output logic       busy,
	output logic       done
);

	bgas_state_t state_q, state_d;
	logic        accept;

	assign accept = start && (state_q == S_IDLE);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		ctrl    = '0;
		busy    = 1'b1;
		done    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (accept) begin
					unique case (bgas_cmd_t'(cmd))
						CMD_LOAD_A: ctrl.load_a = 1'b1;
						CMD_LOAD_B: ctrl.load_b = 1'b1;
						CMD_RUN: begin
							ctrl.run_init = 1'b1;
							state_d       = S_PRIME;
						end
						CMD_NOP: ;
						default: ;
					endcase
				end
			end
			S_PRIME: begin
				ctrl.prime = 1'b1;
				state_d    = S_FILL;
			end
			S_FILL: begin
				ctrl.fill = 1'b1;
				if (stat.fill_last) begin
					state_d = stat.diag_zero ? S_DONE : S_RUN;
				end
			end
			S_RUN: begin
				ctrl.step = 1'b1;
				if (stat.diag_one) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				done    = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

/* rtl/bgas_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgas_dp
// Datapath: symbol memories, lane windows, diagonal score rows, result select.
// ----------------------------------------------------------------------------
module bgas_dp
	import bgas_pkg::*;
#(
	parameter int BAND_LANES  = BAND_LANES_DEF,
	parameter int MAX_SEQ_LEN = MAX_SEQ_LEN_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bgas_ctrl_t           ctrl,
	output bgas_stat_t           stat,
	input  logic [POS_W-1:0]     position,
	input  logic [SYM_W-1:0]     symbol,
	input  logic [LEN_W-1:0]     length_a,
	input  logic [LEN_W-1:0]     length_b,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SCORE_W-1:0]   cfg_data,
	output logic [SCORE_W-1:0]   score,
	output logic                 out_of_band
);

	localparam int N      = BAND_LANES;
	localparam int C      = BAND_LANES / 2;
	localparam int AW     = $clog2(MAX_SEQ_LEN);
	localparam int LENW   = $clog2(MAX_SEQ_LEN + 1);
	localparam int IDXW   = $clog2(MAX_SEQ_LEN + BAND_LANES) + 2;
	localparam int LW     = $clog2(BAND_LANES);
	localparam int FCW    = $clog2(BAND_LANES);

	// configuration registers
	logic [SCORE_W-1:0] match_q, mismatch_q, gap_q, minf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q    <= 16'sd1;
			mismatch_q <= 16'hFFFF;
			gap_q      <= 16'hFFFF;
			minf_q     <= 16'hC000;
		end else if (cfg_we) begin
			unique case (bgas_reg_t'(cfg_index))
				REG_MATCH:     match_q    <= cfg_data;
				REG_MISMATCH:  mismatch_q <= cfg_data;
				REG_GAP:       gap_q      <= cfg_data;
				REG_MINUS_INF: minf_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// run registers
	logic [LENW-1:0]        la_q, lb_q;
	logic [LENW:0]          rem_q;
	logic signed [IDXW-1:0] nxt_a_q, nxt_b_q;
	logic [FCW-1:0]         fill_cnt_q;
	logic                   odd_q, par_q, oob_q;
	logic [LW-1:0]          lane_q;

	// saturate lengths and place the end lane
	logic [31:0]            la32, lb32, pos32;
	logic [LENW-1:0]        la_s, lb_s;
	logic signed [LENW+2:0] lane_i, dl;

	assign la32 = 32'(length_a);
	assign lb32 = 32'(length_b);
	assign pos32 = 32'(position);
	assign la_s = (la32 > 32'(MAX_SEQ_LEN)) ? LENW'(MAX_SEQ_LEN) : la32[LENW-1:0];
	assign lb_s = (lb32 > 32'(MAX_SEQ_LEN)) ? LENW'(MAX_SEQ_LEN) : lb32[LENW-1:0];

	always_comb begin
		if (la_s >= lb_s) begin
			dl = ($signed({3'b000, la_s}) - $signed({3'b000, lb_s})) >>> 1;
		end else begin
			dl = -(($signed({3'b000, lb_s}) - $signed({3'b000, la_s})
				+ (LENW+3)'(1)) >>> 1);
		end
		lane_i = (LENW+3)'(C) + dl;
	end

	// symbol memories
	logic             we_a, we_b, re_a, re_b, shift_a, shift_b;
	logic [AW-1:0]    waddr, raddr_a, raddr_b;
	logic [SYM_W-1:0] rdata_a, rdata_b, sym_a, sym_b;
	logic signed [IDXW-1:0] ra_idx, rb_idx;
	logic             pos_ok;

	assign pos_ok  = pos32 < 32'(MAX_SEQ_LEN);
	assign we_a    = ctrl.load_a && pos_ok;
	assign we_b    = ctrl.load_b && pos_ok;
	assign waddr   = pos32[AW-1:0];
	assign shift_a = ctrl.fill || (ctrl.step && odd_q);
	assign shift_b = ctrl.fill || (ctrl.step && !odd_q);
	assign re_a    = ctrl.prime || shift_a;
	assign re_b    = ctrl.prime || shift_b;
	assign ra_idx  = ctrl.prime ? nxt_a_q : nxt_a_q + IDXW'(1);
	assign rb_idx  = ctrl.prime ? nxt_b_q : nxt_b_q + IDXW'(1);
	assign raddr_a = ra_idx[AW-1:0];
	assign raddr_b = rb_idx[AW-1:0];

	bgas_ram #(.WIDTH(SYM_W), .DEPTH(MAX_SEQ_LEN)) u_ram_a (
		.clk(clk), .we(we_a), .waddr(waddr), .wdata(symbol),
		.re(re_a), .raddr(raddr_a), .rdata(rdata_a)
	);

	bgas_ram #(.WIDTH(SYM_W), .DEPTH(MAX_SEQ_LEN)) u_ram_b (
		.clk(clk), .we(we_b), .waddr(waddr), .wdata(symbol),
		.re(re_b), .raddr(raddr_b), .rdata(rdata_b)
	);

	// pad positions outside each sequence
	assign sym_a = (nxt_a_q >= 0 && nxt_a_q < $signed({{(IDXW-LENW){1'b0}}, la_q}))
		? rdata_a : PAD_A;
	assign sym_b = (nxt_b_q >= 0 && nxt_b_q < $signed({{(IDXW-LENW){1'b0}}, lb_q}))
		? rdata_b : PAD_B;

	// lane windows and score rows
	logic [SYM_W-1:0]   win_a_q [N];
	logic [SYM_W-1:0]   win_b_q [N];
	logic [SYM_W-1:0]   wa_n [N];
	logic [SYM_W-1:0]   wb_n [N];
	logic [SCORE_W-1:0] odd_s_q [N];
	logic [SCORE_W-1:0] even_s_q [N];
	logic [SCORE_W-1:0] next_s [N];

	for (genvar k = 0; k < N; k++) begin : g_lane
		logic [SCORE_W-1:0] sub, diag, side, xmove;

		if (k == N - 1) begin : g_top
			assign wa_n[k] = shift_a ? sym_a : win_a_q[k];
		end else begin : g_mid_a
			assign wa_n[k] = shift_a ? win_a_q[k+1] : win_a_q[k];
		end
		if (k == 0) begin : g_bot
			assign wb_n[k] = shift_b ? sym_b : win_b_q[k];
		end else begin : g_mid_b
			assign wb_n[k] = shift_b ? win_b_q[k-1] : win_b_q[k];
		end

		assign sub  = (wa_n[k] == wb_n[k]) ? match_q : mismatch_q;
		assign diag = (odd_q ? odd_s_q[k] : even_s_q[k]) + sub;
		assign side = (odd_q ? even_s_q[k] : odd_s_q[k]) + gap_q;

		if (k == 0) begin : g_c0
			assign xmove = odd_q ? (even_s_q[k+1] + gap_q) : minf_q;
		end else if (k == N - 1) begin : g_cn
			assign xmove = odd_q ? minf_q : (odd_s_q[k-1] + gap_q);
		end else begin : g_cm
			assign xmove = odd_q ? (even_s_q[k+1] + gap_q) : (odd_s_q[k-1] + gap_q);
		end

		// best of the three moves, edge lanes forced
		always_comb begin
			if (k == 0 || (k == N - 1 && odd_q)) begin
				next_s[k] = minf_q;
			end else begin
				next_s[k] = smax(smax(smax(minf_q, diag), xmove), side);
			end
		end
	end

	// advance windows and rows
	always_ff @(posedge clk) begin
		for (int k = 0; k < N; k++) begin
			if (shift_a) begin
				win_a_q[k] <= wa_n[k];
			end
			if (shift_b) begin
				win_b_q[k] <= wb_n[k];
			end
			if (ctrl.run_init) begin
				odd_s_q[k]  <= minf_q;
				even_s_q[k] <= (k == C) ? '0 : minf_q;
			end else if (ctrl.step) begin
				if (odd_q) begin
					odd_s_q[k] <= next_s[k];
				end else begin
					even_s_q[k] <= next_s[k];
				end
			end
		end
	end

	// run bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			la_q       <= '0;
			lb_q       <= '0;
			rem_q      <= '0;
			nxt_a_q    <= '0;
			nxt_b_q    <= '0;
			fill_cnt_q <= '0;
			odd_q      <= 1'b1;
			par_q      <= 1'b0;
			oob_q      <= 1'b0;
			lane_q     <= '0;
		end else begin
			if (ctrl.run_init) begin
				la_q       <= la_s;
				lb_q       <= lb_s;
				rem_q      <= {1'b0, la_s} + {1'b0, lb_s};
				nxt_a_q    <= -IDXW'(C + 1);
				nxt_b_q    <= IDXW'(C - N);
				fill_cnt_q <= '0;
				odd_q      <= 1'b1;
				par_q      <= la_s[0] ^ lb_s[0];
				oob_q      <= (lane_i < 0) || (lane_i >= (LENW+3)'(N));
				lane_q     <= lane_i[LW-1:0];
			end
			if (shift_a) begin
				nxt_a_q <= nxt_a_q + IDXW'(1);
			end
			if (shift_b) begin
				nxt_b_q <= nxt_b_q + IDXW'(1);
			end
			if (ctrl.fill) begin
				fill_cnt_q <= fill_cnt_q + FCW'(1);
			end
			if (ctrl.step) begin
				rem_q <= rem_q - (LENW+1)'(1);
				odd_q <= !odd_q;
			end
		end
	end

	assign stat.fill_last = (fill_cnt_q == FCW'(N - 1));
	assign stat.diag_zero = (rem_q == '0);
	assign stat.diag_one  = (rem_q == (LENW+1)'(1));

	// result select
	assign out_of_band = oob_q;
	assign score = oob_q ? '0 : (par_q ? odd_s_q[lane_q] : even_s_q[lane_q]);

endmodule

/* rtl/banded_global_alignment_score.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banded_global_alignment_score
// Banded Needleman-Wunsch score, one anti-diagonal per cycle.
// ----------------------------------------------------------------------------
// Load requests give no result.
// A run request goes from accept to the done strobe through a memory prime
// step, a window fill of BAND_LANES symbols, one sweep step per anti-diagonal
// and a result step. busy is high from the prime step to the result step.
// done shows for one cycle, with score and out_of_band valid; no stall.
// Reset (arst_n low) returns to idle and restores register defaults.
module banded_global_alignment_score
	import bgas_pkg::*;
#(
	parameter int BAND_LANES  = BAND_LANES_DEF,
	parameter int MAX_SEQ_LEN = MAX_SEQ_LEN_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           cmd,
	input  logic [POS_W-1:0]     position,
	input  logic [SYM_W-1:0]     symbol,
	input  logic [LEN_W-1:0]     length_a,
	input  logic [LEN_W-1:0]     length_b,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SCORE_W-1:0]   cfg_data,
	output logic                 done,
	output logic [SCORE_W-1:0]   score,
	output logic                 out_of_band
);

	bgas_ctrl_t ctrl;
	bgas_stat_t stat;

	bgas_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd),
		.stat(stat), .ctrl(ctrl), .busy(busy), .done(done)
	);

	bgas_dp #(.BAND_LANES(BAND_LANES), .MAX_SEQ_LEN(MAX_SEQ_LEN)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .stat(stat),
		.position(position), .symbol(symbol),
		.length_a(length_a), .length_b(length_b),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.score(score), .out_of_band(out_of_band)
	);

endmodule

/* rtl/bgas_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgas_checker
// Port-level checks of the run request and result timing.
// ----------------------------------------------------------------------------
module bgas_checker
	import bgas_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic [1:0]         cmd,
	input logic               done,
	input logic [SCORE_W-1:0] score,
	input logic               out_of_band
);

	// a run request makes the block busy
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd == CMD_RUN |=> busy)
		else $error("run request did not raise busy");

	// a result appears only inside a run
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result outside a run");

	// busy drops only right after the result
	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(done))
		else $error("run ended without a result");

	// one result per run
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result repeated");

	// out of band carries a zero score
	a_oob_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && out_of_band |-> score == '0)
		else $error("out of band score not zero");

endmodule

bind banded_global_alignment_score bgas_checker u_bgas_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
	.done(done), .score(score), .out_of_band(out_of_band)
);

/* tb/banded_global_alignment_score_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banded_global_alignment_score_checker
// Watches the request, configuration and result ports of the alignment
// scorer. It keeps its own copy of both symbol stores and of the scoring
// registers, predicts the score of every accepted run request and compares
// each done strobe with the oldest predicted score.
// ----------------------------------------------------------------------------
module banded_global_alignment_score_checker
	import bgas_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  logic [1:0]           cmd,
	input  logic [POS_W-1:0]     position,
	input  logic [SYM_W-1:0]     symbol,
	input  logic [LEN_W-1:0]     length_a,
	input  logic [LEN_W-1:0]     length_b,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SCORE_W-1:0]   cfg_data,
	input  logic                 done,
	input  logic [SCORE_W-1:0]   score,
	input  logic                 out_of_band,
	output int                   fail_count,
	output int                   pending
);

	localparam int LANES  = 16;
	localparam int MID    = LANES / 2;
	localparam int SEQ_SZ = 1024;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic               oob;
	} align_result_t;

	logic [SYM_W-1:0]   seq_a_mem [SEQ_SZ];
	logic [SYM_W-1:0]   seq_b_mem [SEQ_SZ];
	logic [SCORE_W-1:0] w_match, w_mismatch, w_gap, w_neg_inf;
	align_result_t      score_queue[$];

	function automatic logic [SCORE_W-1:0] best_of(input logic [SCORE_W-1:0] x,
		input logic [SCORE_W-1:0] y);
		if ($signed(y) > $signed(x))
			return y;
		return x;
	endfunction

	function automatic logic [SYM_W-1:0] sym_a(input int idx, input int len);
		if (idx >= 0 && idx < len)
			return seq_a_mem[idx];
		return PAD_A;
	endfunction

	function automatic logic [SYM_W-1:0] sym_b(input int idx, input int len);
		if (idx >= 0 && idx < len)
			return seq_b_mem[idx];
		return PAD_B;
	endfunction

	// score one run over the band, one anti-diagonal per pass
	function automatic align_result_t align_score(input int la_in, input int lb_in);
		logic [SCORE_W-1:0] odd_d [LANES];
		logic [SCORE_W-1:0] even_d [LANES];
		logic [SCORE_W-1:0] nxt [LANES];
		logic [SYM_W-1:0]   win_a [LANES];
		logic [SYM_W-1:0]   win_b [LANES];
		logic [SCORE_W-1:0] sub, diag, lt, upv;
		align_result_t      res;
		int la, lb, ia, ib, shift, lane;
		la = (la_in > SEQ_SZ) ? SEQ_SZ : la_in;
		lb = (lb_in > SEQ_SZ) ? SEQ_SZ : lb_in;
		for (int k = 0; k < LANES; k++) begin
			odd_d[k] = w_neg_inf;
			even_d[k] = w_neg_inf;
			win_a[k] = sym_a(k - MID - 1, la);
			win_b[k] = sym_b(MID - 1 - k, lb);
		end
		even_d[MID] = '0;
		ia = LANES - MID - 2;
		ib = MID - 1;
		for (int d = 1; d <= la + lb; d++) begin
			if (d % 2 == 1) begin
				// odd diagonal: shift A toward lane 0
				ia++;
				for (int k = 0; k < LANES - 1; k++)
					win_a[k] = win_a[k + 1];
				win_a[LANES - 1] = sym_a(ia, la);
				for (int k = 0; k < LANES; k++) begin
					sub = (win_a[k] == win_b[k]) ? w_match : w_mismatch;
					diag = odd_d[k] + sub;
					upv = even_d[k] + w_gap;
					lt = (k < LANES - 1) ? even_d[k + 1] + w_gap : w_neg_inf;
					nxt[k] = best_of(best_of(best_of(w_neg_inf, diag), lt), upv);
				end
				nxt[0] = w_neg_inf;
				nxt[LANES - 1] = w_neg_inf;
				odd_d = nxt;
			end else begin
				// even diagonal: shift B toward the top lane
				ib++;
				for (int k = LANES - 1; k > 0; k--)
					win_b[k] = win_b[k - 1];
				win_b[0] = sym_b(ib, lb);
				for (int k = 0; k < LANES; k++) begin
					sub = (win_a[k] == win_b[k]) ? w_match : w_mismatch;
					diag = even_d[k] + sub;
					lt = odd_d[k] + w_gap;
					upv = (k > 0) ? odd_d[k - 1] + w_gap : w_neg_inf;
					nxt[k] = best_of(best_of(best_of(w_neg_inf, diag), lt), upv);
				end
				nxt[0] = w_neg_inf;
				even_d = nxt;
			end
		end
		shift = (la >= lb) ? ((la - lb) >>> 1) : -((lb - la + 1) >>> 1);
		lane = MID + shift;
		if (lane < 0 || lane >= LANES) begin
			res.score = '0;
			res.oob = 1'b1;
		end else begin
			res.score = ((la + lb) % 2 == 1) ? odd_d[lane] : even_d[lane];
			res.oob = 1'b0;
		end
		return res;
	endfunction

	assign pending = score_queue.size();

	// track registers and stores, predict runs
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_match <= 16'sd1;
			w_mismatch <= -16'sd1;
			w_gap <= -16'sd1;
			w_neg_inf <= -16'sd16384;
		end else begin
			if (cfg_we) begin
				case (bgas_reg_t'(cfg_index))
					REG_MATCH: w_match <= cfg_data;
					REG_MISMATCH: w_mismatch <= cfg_data;
					REG_GAP: w_gap <= cfg_data;
					REG_MINUS_INF: w_neg_inf <= cfg_data;
					default: ;
				endcase
			end
			if (start && !busy) begin
				case (bgas_cmd_t'(cmd))
					CMD_LOAD_A: seq_a_mem[position] = symbol;
					CMD_LOAD_B: seq_b_mem[position] = symbol;
					CMD_RUN: score_queue.push_back(align_score(length_a, length_b));
					default: ;
				endcase
			end
		end
	end

	// compare each result with the oldest prediction
	initial fail_count = 0;
	always @(posedge clk) begin
		align_result_t want;
		if (arst_n && done) begin
			if (score_queue.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result: score %h out_of_band %b", score, out_of_band);
			end else begin
				want = score_queue.pop_front();
				if (want.score !== score || want.oob !== out_of_band) begin
					fail_count++;
					if (fail_count <= 10)
						$display("mismatch: expected score %h oob %b, got score %h oob %b",
							want.score, want.oob, score, out_of_band);
				end
			end
		end
	end

endmodule

/* tb/banded_global_alignment_score_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banded_global_alignment_score_test
// Stimulus for the banded alignment scorer: fills the low end of both symbol
// stores, runs a directed set of corner runs, then random load and run
// requests under a series of scoring settings with random gaps. The checker
// predicts scores.
// ----------------------------------------------------------------------------
module banded_global_alignment_score_test;
	import bgas_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [1:0]         cmd = CMD_NOP;
	logic [POS_W-1:0]   position = '0;
	logic [SYM_W-1:0]   symbol = '0;
	logic [LEN_W-1:0]   length_a = '0;
	logic [LEN_W-1:0]   length_b = '0;
	logic               cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [SCORE_W-1:0] cfg_data = '0;
	logic               busy, done, out_of_band;
	logic [SCORE_W-1:0] score;
	int                 fail_count, pending;
	bit                 no_gaps;

	banded_global_alignment_score i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.position(position), .symbol(symbol), .length_a(length_a),
		.length_b(length_b), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done), .score(score), .out_of_band(out_of_band)
	);

	banded_global_alignment_score_checker i_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.position(position), .symbol(symbol), .length_a(length_a),
		.length_b(length_b), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done), .score(score), .out_of_band(out_of_band),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// hard stop
	initial begin
		#40ms;
		$display("banded_global_alignment_score verification failed");
		$finish;
	end

	// present one request and hold it until accepted
	task automatic send_request(input bgas_cmd_t c, input logic [POS_W-1:0] p,
		input logic [SYM_W-1:0] s, input logic [LEN_W-1:0] la, input logic [LEN_W-1:0] lb);
		int gap;
		gap = 0;
		if (!no_gaps) begin
			gap = int'($urandom_range(0, 99));
			gap = (gap < 60) ? 0 :
				(gap < 95) ? int'($urandom_range(1, 4)) : int'($urandom_range(10, 60));
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		position <= p;
		symbol <= s;
		length_a <= la;
		length_b <= lb;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	// drop start, let all runs finish and loads settle
	task automatic drain;
		start <= 1'b0;
		@(posedge clk);
		while (busy !== 1'b0 || pending != 0) @(posedge clk);
		repeat (25) @(posedge clk);
	endtask

	task automatic write_scores(input logic [SCORE_W-1:0] m, input logic [SCORE_W-1:0] mm,
		input logic [SCORE_W-1:0] g, input logic [SCORE_W-1:0] ni);
		cfg_we <= 1'b1;
		cfg_index <= REG_MATCH;
		cfg_data <= m;
		@(posedge clk);
		cfg_index <= REG_MISMATCH;
		cfg_data <= mm;
		@(posedge clk);
		cfg_index <= REG_GAP;
		cfg_data <= g;
		@(posedge clk);
		cfg_index <= REG_MINUS_INF;
		cfg_data <= ni;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [SYM_W-1:0] pick_symbol();
		logic [SYM_W-1:0] alpha [6] = '{8'h31, 8'h32, 8'h41, 8'h43, 8'h47, 8'h54};
		if ($urandom_range(0, 3) == 0)
			return SYM_W'($urandom_range(0, 255));
		return alpha[$urandom_range(0, 5)];
	endfunction

	function automatic logic [POS_W-1:0] pick_position();
		if ($urandom_range(0, 9) == 0)
			return POS_W'($urandom_range(0, 1023));
		return POS_W'($urandom_range(0, 63));
	endfunction

	task automatic random_request;
		int r;
		logic [LEN_W-1:0] la, lb;
		r = int'($urandom_range(0, 99));
		la = LEN_W'($urandom_range(0, 40));
		lb = LEN_W'($urandom_range(0, 40));
		if (r < 33 || r >= 97) begin
			send_request(r < 33 ? CMD_LOAD_A : CMD_NOP, pick_position(), pick_symbol(),
				LEN_W'($urandom_range(0, 2047)), LEN_W'($urandom_range(0, 2047)));
		end else if (r < 64) begin
			send_request(CMD_LOAD_B, pick_position(), pick_symbol(),
				LEN_W'($urandom_range(0, 2047)), LEN_W'($urandom_range(0, 2047)));
		end else begin
			// rare long runs reach the upper length bits and saturation, out of band
			if ($urandom_range(0, 199) == 0) begin
				la = LEN_W'($urandom_range(1100, 2047));
				lb = LEN_W'($urandom_range(0, 40));
				if ($urandom_range(0, 1) == 0) begin
					{la, lb} = {lb, la};
				end
			end else if ($urandom_range(0, 3) == 0) begin
				lb = LEN_W'(la + $urandom_range(0, 3) - 1);
			end
			send_request(CMD_RUN, POS_W'($urandom_range(0, 1023)),
				SYM_W'($urandom_range(0, 255)), la, lb);
		end
	endtask

	initial begin
		no_gaps = 1'b1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_scores(16'sd1, -16'sd1, -16'sd1, -16'sd16384);

		// fill the low end of both stores; every in-band run stays inside it
		for (int i = 0; i < 64; i++) begin
			send_request(CMD_LOAD_A, POS_W'(i), pick_symbol(), '0, '0);
			send_request(CMD_LOAD_B, POS_W'(i), pick_symbol(), '0, '0);
		end

		// corner requests
		no_gaps = 1'b0;
		send_request(CMD_LOAD_A, 10'd1023, 8'h00, 11'h7FF, 11'h7FF);
		send_request(CMD_LOAD_B, 10'd1023, 8'hFF, 11'h000, 11'h000);
		send_request(CMD_LOAD_A, 10'd0, 8'hFF, '0, '0);
		send_request(CMD_NOP, 10'h3FF, 8'hFF, 11'h7FF, 11'h7FF);
		send_request(CMD_RUN, '0, '0, 11'd0, 11'd0);
		send_request(CMD_RUN, '0, '0, 11'd1, 11'd0);
		send_request(CMD_RUN, '0, '0, 11'd0, 11'd1);
		send_request(CMD_RUN, '0, '0, 11'd15, 11'd0);
		send_request(CMD_RUN, '0, '0, 11'd16, 11'd0);
		send_request(CMD_RUN, '0, '0, 11'd0, 11'd15);
		send_request(CMD_RUN, '0, '0, 11'd0, 11'd17);
		send_request(CMD_RUN, '0, '0, 11'd1024, 11'd0);
		send_request(CMD_RUN, 10'h3FF, 8'hFF, 11'h7FF, 11'd5);
		send_request(CMD_RUN, '0, '0, 11'd64, 11'd60);
		send_request(CMD_RUN, '0, '0, 11'd30, 11'd31);
		drain();

		// random phases under several scoring settings
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: write_scores(16'sd2, -16'sd3, -16'sd2, -16'sd16384);
				1: write_scores(16'h7FFF, 16'h8000, 16'h8000, 16'h8000);
				2: write_scores(16'h0000, 16'h0000, 16'h0000, 16'h7FFF);
				3: write_scores(16'h8000, 16'h7FFF, 16'h7FFF, 16'h0000);
				7: write_scores(16'sd1, -16'sd1, -16'sd1, -16'sd16384);
				default: write_scores(SCORE_W'($urandom), SCORE_W'($urandom),
					SCORE_W'($urandom), SCORE_W'($urandom));
			endcase
			for (int n = 0; n < 135; n++) begin
				if (n % 40 == 0)
					no_gaps = ($urandom_range(0, 3) == 0);
				random_request();
			end
			no_gaps = 1'b0;
			drain();
		end

		repeat (40) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("banded_global_alignment_score verification clean");
		else
			$display("banded_global_alignment_score verification failed");
		$finish;
	end

endmodule
